[rtl/sorted_book_search_and_pick_top_macros.svh]
// assertion macros for the book search controller
// depends on nothing; included by sbk_ctrl
`ifndef SORTED_BOOK_SEARCH_AND_PICK_TOP_MACROS_SVH
`define SORTED_BOOK_SEARCH_AND_PICK_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define SBK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define SBK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[rtl/sbk_pkg.sv]
// package for the sorted book search block: widths, commands, control structs
// depends on nothing
`default_nettype none
package sbk_pkg;
	localparam int BookDepth = 4096;
	localparam int MaxRun = 128;
	localparam int AddrW = $clog2(BookDepth);
	localparam int TotW = $clog2(BookDepth + 1);
	localparam int RunW = $clog2(MaxRun + 1);
	localparam int KeyW = 64;
	localparam int EntW = KeyW + 32;

	localparam logic [1:0] CmdClear = 2'd0;
	localparam logic [1:0] CmdLoad = 2'd1;
	localparam logic [1:0] CmdQuery = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic load;
		logic capture;
		logic srch_init;
		logic srch_rd;
		logic srch_upd;
		logic cand_rd;
		logic cand_chk;
		logic scan_init;
		logic scan_rd;
		logic scan_step;
		logic half_calc;
		logic mod_init;
		logic mod_step;
		logic fin;
		logic miss;
	} sbk_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic srch_done;
		logic key_hit;
		logic scan_done;
		logic mod_done;
	} sbk_stat_t;
endpackage
`default_nettype wire

[rtl/sorted_book_search_and_pick_top.sv]
// clear and load finish without leaving idle; a query runs a binary search,
// then on a key hit three scans of the matching run and a modulo, its time
// bounded by the single ram port; one item at a time, busy held in a query;
// the receiver cannot stall; one result strobe per query
// reset (arst_n low) empties the table; table contents are not cleared
`default_nettype none
module sorted_book_search_and_pick_top import sbk_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] cmd,
	input wire logic [63:0] entry_key,
	input wire logic [15:0] move_code,
	input wire logic [15:0] move_weight,
	input wire logic [31:0] random_value,
	output logic valid,
	output logic found,
	output logic [2:0] dest_col,
	output logic [2:0] dest_row,
	output logic [2:0] from_col,
	output logic [2:0] from_row,
	output logic [3:0] promotion,
	output logic [7:0] match_count,
	output logic [11:0] first_index
);
	sbk_cmd_t ctl;
	sbk_stat_t stat;
	logic rv, rf;
	logic [15:0] mv;
	logic [RunW-1:0] rr;
	logic [AddrW-1:0] rs;
	logic f_q;
	logic [15:0] mv_q;
	logic [7:0] cnt_q;
	logic [11:0] idx_q;

	sbk_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.stat(stat), .ctl(ctl), .busy(busy));

	sbk_dp u_dp (.clk(clk), .arst_n(arst_n), .ctl(ctl), .entry_key(entry_key),
		.move_code(move_code), .move_weight(move_weight), .random_value(random_value),
		.stat(stat), .res_valid(rv), .res_found(rf), .res_move(mv), .res_run(rr),
		.res_start(rs));

	// result register, zeroed on a miss
	always_ff @(posedge clk) begin
		if (ctl.fin || ctl.miss) begin
			f_q <= rf;
			mv_q <= rf ? mv : 16'd0;
			cnt_q <= rf ? 8'(rr) : 8'd0;
			idx_q <= rf ? 12'(rs) : 12'd0;
		end
	end

	assign valid = rv;
	assign found = f_q;
	assign dest_col = mv_q[2:0];
	assign dest_row = mv_q[5:3];
	assign from_col = mv_q[8:6];
	assign from_row = mv_q[11:9];
	assign promotion = mv_q[15:12];
	assign match_count = cnt_q;
	assign first_index = idx_q;
endmodule
`default_nettype wire

[rtl/sbk_ram.sv]
// generic single-port ram with registered read
// depends on nothing
`default_nettype none
module sbk_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] addr,
	input wire logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	// write or read one word a cycle
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

[rtl/sbk_ctrl.sv]
// controller for the book search: sequences search, scans, modulo, result
// depends on sbk_pkg and the macro header
`default_nettype none
`include "sorted_book_search_and_pick_top_macros.svh"
module sbk_ctrl import sbk_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [1:0] cmd,
	input wire sbk_stat_t stat,
	output sbk_cmd_t ctl,
	output logic busy
);
	typedef enum logic [10:0] {
		StIdle = 11'b00000000001,
		StSrch = 11'b00000000010,
		StSrchW = 11'b00000000100,
		StCand = 11'b00000001000,
		StCandW = 11'b00000010000,
		StScan1 = 11'b00000100000,
		StHalf = 11'b00001000000,
		StScan2 = 11'b00010000000,
		StMod = 11'b00100000000,
		StScan3 = 11'b01000000000,
		StDone = 11'b10000000000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] pass_q;

	assign busy = state_q != StIdle;

	// next state and commands
	always_comb begin
		state_d = state_q;
		ctl = '0;
		case (state_q)
			StIdle: begin
				if (start) begin
					ctl.capture = 1'b1;
					if (cmd == CmdClear) ctl.clear = 1'b1;
					else if (cmd == CmdLoad) ctl.load = 1'b1;
					else if (cmd == CmdQuery) begin
						if (stat.empty) ctl.miss = 1'b1;
						else begin
							ctl.srch_init = 1'b1;
							state_d = StSrch;
						end
					end
				end
			end
			StSrch: begin
				if (stat.srch_done) begin
					ctl.cand_rd = 1'b1;
					state_d = StCandW;
				end else begin
					ctl.srch_rd = 1'b1;
					state_d = StSrchW;
				end
			end
			StSrchW: begin
				ctl.srch_upd = 1'b1;
				state_d = StSrch;
			end
			StCandW: begin
				// keep the candidate address on the ram port
				ctl.cand_rd = 1'b1;
				state_d = StCand;
			end
			StCand: begin
				ctl.cand_chk = 1'b1;
				if (stat.key_hit) begin
					ctl.scan_init = 1'b1;
					state_d = StScan1;
				end else begin
					ctl.miss = 1'b1;
					state_d = StIdle;
				end
			end
			StScan1, StScan2, StScan3: begin
				if (stat.scan_done) begin
					if (state_q == StScan1) state_d = StHalf;
					else if (state_q == StScan2) state_d = StMod;
					else state_d = StDone;
				end else begin
					ctl.scan_rd = 1'b1;
					ctl.scan_step = 1'b1;
				end
			end
			StHalf: begin
				ctl.half_calc = 1'b1;
				ctl.scan_init = 1'b1;
				state_d = StScan2;
			end
			StMod: begin
				if (pass_q == 2'd0) ctl.mod_init = 1'b1;
				else if (stat.mod_done) begin
					ctl.scan_init = 1'b1;
					state_d = StScan3;
				end else ctl.mod_step = 1'b1;
			end
			StDone: begin
				ctl.fin = 1'b1;
				state_d = StIdle;
			end
			default: state_d = StIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			pass_q <= 2'd0;
		end else begin
			state_q <= state_d;
			pass_q <= (state_q == StMod && state_d == StMod) ? 2'd1 : 2'd0;
		end
	end

	`SBK_ASSERT_IMP(a_fin_from_done, clk, arst_n, ctl.fin, state_q == StDone)
	`SBK_ASSERT_NEXT(a_done_idle, clk, arst_n, state_q == StDone, state_q == StIdle)
	`SBK_ASSERT_IMP(a_idle_accept, clk, arst_n, ctl.capture, !busy)
endmodule
`default_nettype wire

[rtl/sbk_dp.sv]
// datapath for the book search: table ram, search bounds, run scans, modulo
// depends on sbk_pkg and sbk_ram
`default_nettype none
module sbk_dp import sbk_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire sbk_cmd_t ctl,
	input wire logic [KeyW-1:0] entry_key,
	input wire logic [15:0] move_code,
	input wire logic [15:0] move_weight,
	input wire logic [31:0] random_value,
	output sbk_stat_t stat,
	output logic res_valid,
	output logic res_found,
	output logic [15:0] res_move,
	output logic [RunW-1:0] res_run,
	output logic [AddrW-1:0] res_start
);
	logic [TotW-1:0] total_q;
	logic [KeyW-1:0] key_q;
	logic [31:0] rnd_q;
	logic [TotW:0] lo_q, hi_q;
	logic [TotW:0] mid;
	logic [AddrW-1:0] addr;
	logic we;
	logic [EntW-1:0] rdata;
	logic [KeyW-1:0] rkey;
	logic [15:0] rmove, rweight;
	logic [AddrW-1:0] start_q;
	logic [RunW-1:0] idx_q, run_q;
	logic [1:0] pass_q;
	logic rd_pend_q, stop_q;
	logic [15:0] maxw_q, half_q, move_q;
	logic [RunW-1:0] kept_q, seen_q;
	logic [31:0] rem_q;
	logic [RunW-1:0] pick_q;
	logic [5:0] mbit_q;
	logic got_q;
	logic [TotW:0] pos;
	logic qual;
	logic [32:0] trial;

	assign rkey = rdata[EntW-1 -: KeyW];
	assign rmove = rdata[31:16];
	assign rweight = rdata[15:0];
	assign mid = (lo_q + hi_q) >> 1;
	assign pos = {1'b0, {(TotW - AddrW){1'b0}}, start_q} + {{(TotW + 1 - RunW){1'b0}}, idx_q};
	assign we = ctl.load && total_q < TotW'(BookDepth);

	// single ram address mux
	always_comb begin
		if (we) addr = total_q[AddrW-1:0];
		else if (ctl.srch_rd) addr = mid[AddrW-1:0];
		else if (ctl.cand_rd) addr = hi_q[AddrW-1:0];
		else addr = pos[AddrW-1:0];
	end

	sbk_ram #(.Width(EntW), .Depth(BookDepth)) u_ram (
		.clk(clk), .we(we), .addr(addr),
		.wdata({entry_key, move_code, move_weight}), .rdata(rdata)
	);

	assign qual = rweight > half_q;
	assign trial = {rem_q, rnd_q[5'd31 - mbit_q[4:0]]} - {{(33 - RunW){1'b0}}, kept_q};
	assign stat.empty = total_q == '0;
	assign stat.srch_done = (hi_q - lo_q) <= (TotW + 1)'(1);
	assign stat.key_hit = rkey == key_q;
	assign stat.scan_done = stop_q;
	assign stat.mod_done = mbit_q == 6'd32;

	// table fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) total_q <= '0;
		else if (ctl.clear) total_q <= '0;
		else if (we) total_q <= total_q + 1'b1;
	end

	// search, scans, modulo
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
			pass_q <= '0;
			rd_pend_q <= 1'b0;
			stop_q <= 1'b0;
		end else begin
			res_valid <= ctl.fin || ctl.miss;
			if (ctl.capture) begin
				key_q <= entry_key;
				rnd_q <= random_value;
			end
			if (ctl.srch_init) begin
				lo_q <= '1;
				hi_q <= {1'b0, total_q} - 1'b1;
				pass_q <= '0;
			end
			if (ctl.srch_upd) begin
				if (key_q <= rkey) hi_q <= mid;
				else lo_q <= mid;
			end
			if (ctl.cand_chk) start_q <= hi_q[AddrW-1:0];
			if (ctl.scan_init) begin
				idx_q <= '0;
				rd_pend_q <= 1'b0;
				stop_q <= 1'b0;
				seen_q <= '0;
				got_q <= 1'b0;
				if (ctl.cand_chk) begin
					maxw_q <= '0;
					move_q <= rmove;
				end
				if (!ctl.cand_chk && !ctl.half_calc) pass_q <= 2'd2;
				else if (ctl.half_calc) pass_q <= 2'd1;
				else pass_q <= 2'd0;
			end
			if (ctl.half_calc) begin
				half_q <= maxw_q >> 1;
				run_q <= idx_q;
			end
			if (ctl.scan_step) begin
				// data from the previous read, then issue the next
				if (rd_pend_q) begin
					if (pass_q == 2'd0) begin
						if (rkey != key_q) stop_q <= 1'b1;
						else begin
							if (rweight > maxw_q) maxw_q <= rweight;
							idx_q <= idx_q + 1'b1;
							if (idx_q + 1'b1 == RunW'(MaxRun) ||
									pos + 1'b1 >= {1'b0, total_q}) stop_q <= 1'b1;
						end
					end else begin
						if (qual) begin
							if (pass_q == 2'd1) kept_q <= kept_q + 1'b1;
							else if (!got_q && seen_q == pick_q) begin
								move_q <= rmove;
								got_q <= 1'b1;
							end
							seen_q <= seen_q + 1'b1;
						end
						idx_q <= idx_q + 1'b1;
						if (idx_q + 1'b1 == run_q) stop_q <= 1'b1;
					end
					rd_pend_q <= 1'b0;
				end else rd_pend_q <= 1'b1;
			end
			if (ctl.half_calc) kept_q <= '0;
			if (ctl.mod_init) begin
				rem_q <= '0;
				mbit_q <= '0;
				pick_q <= '0;
			end
			// restoring remainder, one bit a cycle, msb first
			if (ctl.mod_step) begin
				if (kept_q == '0) begin
					pick_q <= '0;
					mbit_q <= 6'd32;
				end else begin
					if (!trial[32]) rem_q <= trial[31:0];
					else rem_q <= {rem_q[30:0], rnd_q[5'd31 - mbit_q[4:0]]};
					if (!trial[32]) pick_q <= trial[RunW-1:0];
					else pick_q <= {rem_q[RunW-2:0], rnd_q[5'd31 - mbit_q[4:0]]};
					mbit_q <= mbit_q + 1'b1;
				end
			end
		end
	end

	assign res_found = ctl.miss ? 1'b0 : 1'b1;
	assign res_move = move_q;
	assign res_run = run_q;
	assign res_start = start_q;
endmodule
`default_nettype wire
